// ===== sv/sample_hold_noise_generator_macros.svh =====
// Assertion macros shared by the noise generator modules.
// The checks compile away when SYNTH is defined.
`ifndef SAMPLE_HOLD_NOISE_GENERATOR_MACROS_SVH
`define SAMPLE_HOLD_NOISE_GENERATOR_MACROS_SVH

`ifndef SYNTH

`define SHN_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SHN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHN_ASSERT_IMPLY(label, ante, cons, msg)

`define SHN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/shn_pkg.sv =====
package shn_pkg;

  localparam int WORD_W = 32;
  localparam int TW_N   = 624;
  localparam int TW_M   = 397;
  localparam int ADDR_W = $clog2(TW_N + 1);

  localparam logic [ADDR_W-1:0] TW_LAST  = ADDR_W'(TW_N - 1);
  localparam logic [ADDR_W-1:0] TW_FULL  = ADDR_W'(TW_N);
  localparam logic [ADDR_W-1:0] TW_M_OFF = ADDR_W'(TW_M);
  localparam logic [ADDR_W-1:0] TW_WRAP  = ADDR_W'(TW_N - TW_M);

  localparam int MAX_TABLE_LENGTH = 65536;
  localparam int HOLD_W    = 16;
  localparam int LEN_W     = 17;
  localparam int INDEX_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_TABLE_LENGTH);
  localparam logic [LEN_W-1:0]  LEN_ONE  = LEN_W'(1);
  localparam logic [HOLD_W-1:0] HOLD_ONE = HOLD_W'(1);

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd10000;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd64;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 17'd2048;

  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 2'd2;

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SIGN_BIT  = 32'h8000_0000;

  typedef struct packed {
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic tw_pre;
    logic tw_rd;
    logic tw_wr;
    logic draw_skip;
    logic draw_read;
    logic draw_take;
    logic emit;
  } shn_cmd_t;

  typedef struct packed {
    logic start_needed;
    logic countdown_zero;
    logic pos_full;
    logic loop_last;
    logic out_free;
  } shn_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== sv/shn_request_if.sv =====
interface shn_request_if import shn_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== sv/shn_result_if.sv =====
interface shn_result_if import shn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  sample;
  logic        [INDEX_W-1:0] sample_index;
  logic                      last_in_table;

  modport source (output valid, output sample, output sample_index, output last_in_table,
                  input ready);
  modport sink (input valid, input sample, input sample_index, input last_in_table,
                output ready);
endinterface

// ===== sv/shn_cfg_if.sv =====
interface shn_cfg_if import shn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/shn_datapath.sv =====
`include "sample_hold_noise_generator_macros.svh"

module shn_datapath import shn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  shn_cmd_t    cmd,
  output shn_status_t status,
  shn_cfg_if.sink     cfg,
  shn_result_if.source result
);

  logic [WORD_W-1:0]  seed_r;
  logic [HOLD_W-1:0]  hold_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_eff;
  logic [HOLD_W-1:0]  hold_eff;

  logic [WORD_W-1:0]  mem [0:TW_N-1];
  logic               we;
  logic [ADDR_W-1:0]  wa;
  logic [WORD_W-1:0]  wd;
  logic               ra_en;
  logic [ADDR_W-1:0]  ra_addr;
  logic [ADDR_W-1:0]  rb_addr;
  logic [WORD_W-1:0]  rd_a;
  logic [WORD_W-1:0]  rd_b;

  logic [ADDR_W-1:0]  cnt;
  logic [ADDR_W-1:0]  cnt_wrap1;
  logic [ADDR_W-1:0]  cnt_plus_m;
  logic [ADDR_W-1:0]  pos;
  logic [WORD_W-1:0]  prev;
  logic [WORD_W-1:0]  prod;
  logic [WORD_W-1:0]  seed_word;
  logic [WORD_W-1:0]  cur;
  logic [WORD_W-1:0]  twist_y;
  logic [WORD_W-1:0]  twist_word;
  logic [WORD_W-1:0]  held;

  logic [HOLD_W-1:0]  countdown;
  logic [INDEX_W-1:0] tpos;
  logic               needs_reseed;
  logic               is_last;

  logic               out_valid;
  logic [WORD_W-1:0]  out_sample;
  logic [INDEX_W-1:0] out_index;
  logic               out_last;

  // Configuration registers; writes to an unused index are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_r <= SEED_RESET;
      hold_r <= HOLD_RESET;
      len_r  <= LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SEED: seed_r <= cfg.data;
        REG_HOLD: hold_r <= cfg.data[HOLD_W-1:0];
        REG_LEN:  len_r  <= cfg.data[LEN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    len_eff = len_r;
    if (len_r == '0) begin
      len_eff = LEN_ONE;
    end else if (len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
    hold_eff = (hold_r == '0) ? HOLD_ONE : hold_r;
  end

  // Twister state memory: one write port, two registered read ports.
  assign cnt_wrap1  = (cnt == TW_LAST) ? '0 : cnt + 1'b1;
  assign cnt_plus_m = (cnt < TW_WRAP) ? cnt + TW_M_OFF : cnt - TW_WRAP;

  assign seed_word  = prod + WORD_W'(cnt);
  assign twist_y    = {cur[WORD_W-1], rd_a[WORD_W-2:0]};
  assign twist_word = rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);

  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = twist_word;
    if (cmd.seed_init) begin
      we = 1'b1;
      wa = '0;
      wd = seed_r;
    end else if (cmd.seed_add) begin
      we = 1'b1;
      wd = seed_word;
    end else if (cmd.tw_wr) begin
      we = 1'b1;
    end
  end

  assign ra_en   = cmd.tw_pre || cmd.tw_rd || cmd.draw_read;
  assign ra_addr = cmd.draw_read ? pos : (cmd.tw_rd ? cnt_wrap1 : '0);
  assign rb_addr = cnt_plus_m;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ra_en) begin
      rd_a <= mem[ra_addr];
    end
    if (cmd.tw_rd) begin
      rd_b <= mem[rb_addr];
    end
  end

  // Control state of the generator.
  assign is_last = (LEN_W'(tpos) + LEN_ONE) == len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      pos          <= TW_FULL;
      countdown    <= '0;
      tpos         <= '0;
      needs_reseed <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.seed_init) begin
        cnt <= ADDR_W'(1);
      end else if (cmd.tw_pre) begin
        cnt <= '0;
      end else if (cmd.seed_add || cmd.tw_wr) begin
        cnt <= cnt + 1'b1;
      end

      if (cmd.seed_init) begin
        pos <= TW_FULL;
      end else if (cmd.tw_wr && status.loop_last) begin
        pos <= '0;
      end else if (cmd.draw_skip || cmd.draw_read) begin
        pos <= pos + 1'b1;
      end

      if (cmd.seed_init) begin
        countdown <= '0;
      end else if (cmd.draw_take) begin
        countdown <= hold_eff;
      end else if (cmd.emit) begin
        countdown <= countdown - 1'b1;
      end

      if (cmd.seed_init) begin
        tpos         <= '0;
        needs_reseed <= 1'b0;
      end else if (cmd.emit) begin
        if (is_last) begin
          needs_reseed <= 1'b1;
        end else begin
          tpos <= tpos + 1'b1;
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      prev <= seed_r;
    end else if (cmd.seed_add) begin
      prev <= seed_word;
    end
    if (cmd.seed_mul) begin
      prod <= SEED_MULT * (prev ^ (prev >> 30));
    end
    // During a read step the A port still shows word i from the step before.
    if (cmd.tw_rd) begin
      cur <= rd_a;
    end
    if (cmd.draw_take) begin
      held <= temper(rd_a) ^ SIGN_BIT;
    end
    if (cmd.emit) begin
      out_sample <= held;
      out_index  <= tpos;
      out_last   <= is_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.sample        = $signed(out_sample);
  assign result.sample_index  = out_index;
  assign result.last_in_table = out_last;

  assign status.start_needed   = restart || needs_reseed || (LEN_W'(tpos) >= len_eff);
  assign status.countdown_zero = (countdown == '0);
  assign status.pos_full       = (pos >= TW_FULL);
  assign status.loop_last      = (cnt == TW_LAST);
  assign status.out_free       = !out_valid || result.ready;

  `SHN_ASSERT_NEXT(a_twist_resets_pos, cmd.tw_wr && status.loop_last, pos == '0, "twist did not rewind the read position")
  `SHN_ASSERT_IMPLY(a_read_in_range, cmd.draw_read, pos < TW_FULL, "twister read past the state")
  `SHN_ASSERT_NEXT(a_seed_clears_table, cmd.seed_init, (tpos == '0) && !needs_reseed && (countdown == '0), "table start left stale state")

endmodule

// ===== sv/shn_controller.sv =====
`include "sample_hold_noise_generator_macros.svh"

module shn_controller import shn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  shn_request_if.sink  request,
  input  shn_status_t  status,
  output shn_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SEED_INIT = 4'd1;
  localparam logic [3:0] S_SEED_MUL  = 4'd2;
  localparam logic [3:0] S_SEED_ADD  = 4'd3;
  localparam logic [3:0] S_DRAW1     = 4'd4;
  localparam logic [3:0] S_DRAW2     = 4'd5;
  localparam logic [3:0] S_DRAW3     = 4'd6;
  localparam logic [3:0] S_TW_PRE    = 4'd7;
  localparam logic [3:0] S_TW_RD     = 4'd8;
  localparam logic [3:0] S_TW_WR     = 4'd9;
  localparam logic [3:0] S_EMIT      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       twist_ret;
  logic       twist_ret_next;
  logic       accept;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;

  always_comb begin
    state_next     = state;
    twist_ret_next = twist_ret;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.start_needed) begin
            state_next = S_SEED_INIT;
          end else if (status.countdown_zero) begin
            state_next = S_DRAW1;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SEED_INIT: begin
        cmd.seed_init = 1'b1;
        state_next    = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_next   = status.loop_last ? S_DRAW1 : S_SEED_MUL;
      end
      S_DRAW1: begin
        // The first word of each pair is discarded.
        if (status.pos_full) begin
          twist_ret_next = 1'b0;
          state_next     = S_TW_PRE;
        end else begin
          cmd.draw_skip = 1'b1;
          state_next    = S_DRAW2;
        end
      end
      S_DRAW2: begin
        if (status.pos_full) begin
          twist_ret_next = 1'b1;
          state_next     = S_TW_PRE;
        end else begin
          cmd.draw_read = 1'b1;
          state_next    = S_DRAW3;
        end
      end
      S_DRAW3: begin
        cmd.draw_take = 1'b1;
        state_next    = S_EMIT;
      end
      S_TW_PRE: begin
        cmd.tw_pre = 1'b1;
        state_next = S_TW_RD;
      end
      S_TW_RD: begin
        cmd.tw_rd  = 1'b1;
        state_next = S_TW_WR;
      end
      S_TW_WR: begin
        cmd.tw_wr = 1'b1;
        if (status.loop_last) begin
          state_next = twist_ret ? S_DRAW2 : S_DRAW1;
        end else begin
          state_next = S_TW_RD;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      twist_ret <= 1'b0;
    end else begin
      state     <= state_next;
      twist_ret <= twist_ret_next;
    end
  end

  `SHN_ASSERT_IMPLY(a_emit_has_room, cmd.emit, status.out_free, "word emitted into a full output register")
  `SHN_ASSERT_NEXT(a_start_seeds, accept && status.start_needed, state == S_SEED_INIT, "table start did not reseed")
  `SHN_ASSERT_NEXT(a_twist_returns, cmd.tw_wr && status.loop_last, (state == S_DRAW1) || (state == S_DRAW2), "twist did not return to a draw step")

endmodule

// ===== sv/sample_hold_noise_generator.sv =====
// A held value continues straight to the result; a new value is drawn from the
// 624-word twister state, which is regenerated when it is used up and reseeded
// at a table start.
// A new word is accepted only in the idle state, after the last one is emitted;
// the single state memory and the serial seed and twist sequences set the pace.
// Reset: registers take their defaults and the first accepted word reseeds.
module sample_hold_noise_generator import shn_pkg::*; (
  input logic          clk,
  input logic          rst,
  shn_request_if.sink  request,
  shn_result_if.source result,
  shn_cfg_if.sink      cfg
);

  shn_cmd_t    cmd;
  shn_status_t status;

  shn_controller u_controller (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .status  (status),
    .cmd     (cmd)
  );

  shn_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .restart (request.restart),
    .cmd     (cmd),
    .status  (status),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// ===== test/tb_sample_hold_noise_generator.sv =====
module tb_sample_hold_noise_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import shn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 30;

  typedef struct packed {
    logic [WORD_W-1:0]  sample;
    logic [INDEX_W-1:0] index;
    logic               last;
  } noise_word_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [WORD_W-1:0]    data;
    bit                   restart;
    bit                   typed;
    logic [INDEX_W-1:0]   index;
    bit                   last;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  shn_request_if request_ch ();
  shn_result_if  result_ch ();
  shn_cfg_if     cfg_ch ();

  sample_hold_noise_generator DUT (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: configuration copy, twister array and table bookkeeping.
  logic [WORD_W-1:0] seed_reg;
  logic [HOLD_W-1:0] hold_reg;
  logic [LEN_W-1:0]  len_reg;
  logic [WORD_W-1:0] twist_words [TW_N];
  int unsigned       twist_pos;
  logic [WORD_W-1:0] held_sample;
  int unsigned       hold_left;
  int unsigned       tab_pos;
  bit                reseed_due;

  noise_word_t noise_expected [$];
  stim_row_t   directed_rows [$];
  int          errors = 0;
  int unsigned burst_left;
  int unsigned rx_cycle = 0;

  function automatic void twist_reseed(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] p;
    twist_words[0] = s;
    for (int i = 1; i < TW_N; i++) begin
      p = twist_words[i-1];
      twist_words[i] = SEED_MULT * (p ^ (p >> 30)) + WORD_W'(i);
    end
    twist_pos = TW_N;
  endfunction

  function automatic void twist_regen();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    for (int i = 0; i < TW_N; i++) begin
      y = (twist_words[i] & SIGN_BIT) | (twist_words[(i + 1) % TW_N] & ~SIGN_BIT);
      v = twist_words[(i + TW_M) % TW_N] ^ (y >> 1);
      if (y[0]) v = v ^ MATRIX_A;
      twist_words[i] = v;
    end
    twist_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    logic [WORD_W-1:0] y;
    if (twist_pos >= TW_N) twist_regen();
    y = twist_words[twist_pos];
    twist_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic noise_word_t predict_noise(input bit restart);
    int unsigned len;
    int unsigned hold;
    int unsigned idx;
    noise_word_t w;
    len = (len_reg == 0) ? 1 : int'(len_reg);
    if (len > MAX_TABLE_LENGTH) len = MAX_TABLE_LENGTH;
    hold = (hold_reg == 0) ? 1 : int'(hold_reg);
    if (restart || reseed_due || tab_pos >= len) begin
      twist_reseed(seed_reg);
      tab_pos = 0;
      hold_left = 0;
      reseed_due = 0;
    end
    // A new value discards the first twister output and keeps the second.
    if (hold_left == 0) begin
      void'(draw_word());
      held_sample = draw_word() ^ SIGN_BIT;
      hold_left = hold;
    end
    hold_left--;
    idx = tab_pos;
    w.sample = held_sample;
    w.index = idx[INDEX_W-1:0];
    w.last = (idx + 1 == len);
    if (idx + 1 >= len) reseed_due = 1;
    else tab_pos = idx + 1;
    return w;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] r, input logic [WORD_W-1:0] d);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = r;
    row.data = d;
    row.restart = 0;
    row.typed = 0;
    row.index = '0;
    row.last = 0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(input bit restart, input bit typed,
                                   input int unsigned idx, input bit last);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_idx = REG_SEED;
    row.data = '0;
    row.restart = restart;
    row.typed = typed;
    row.index = idx[INDEX_W-1:0];
    row.last = last;
    directed_rows.push_back(row);
  endfunction

  // Random upper bits check that the block keeps only the register's width.
  function automatic logic [WORD_W-1:0] with_junk(input logic [WORD_W-1:0] value,
                                                  input int width);
    logic [WORD_W-1:0] mask;
    mask = (width >= WORD_W) ? '1 : ((32'd1 << width) - 1);
    return ($urandom & ~mask) | (value & mask);
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic wait_idle();
    request_ch.valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] r, input logic [WORD_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (r)
      REG_SEED: seed_reg = d;
      REG_HOLD: hold_reg = d[HOLD_W-1:0];
      REG_LEN:  len_reg = d[LEN_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input bit restart, input bit typed,
                           input logic [INDEX_W-1:0] idx, input bit last);
    noise_word_t w;
    request_ch.valid <= 1'b1;
    request_ch.restart <= restart;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    w = predict_noise(restart);
    if (typed) begin
      w.index = idx;
      w.last = last;
    end
    noise_expected.push_back(w);
    // Bursts end with a gap so valid never drops and rises together.
    burst_left--;
    if (burst_left == 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: result_ch.ready <= 1'b1;
      2'd1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: result_ch.ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
      default: result_ch.ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    noise_word_t w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (noise_expected.size() == 0) begin
        report_error($sformatf("unexpected word sample=%h index=%0d",
                               result_ch.sample, result_ch.sample_index));
      end else begin
        w = noise_expected.pop_front();
        if (result_ch.sample !== w.sample)
          report_error($sformatf("sample %h, expected %h (index %0d)",
                                 result_ch.sample, w.sample, w.index));
        if (result_ch.sample_index !== w.index)
          report_error($sformatf("sample_index %0d, expected %0d",
                                 result_ch.sample_index, w.index));
        if (result_ch.last_in_table !== w.last)
          report_error($sformatf("last_in_table %b, expected %b at index %0d",
                                 result_ch.last_in_table, w.last, w.index));
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("sample_hold_noise_generator: mismatch");
    $finish;
  end

  initial begin
    int unsigned n_items;
    int unsigned restart_pct;
    stim_row_t row;

    rst <= 1'b1;
    request_ch.valid <= 1'b0;
    request_ch.restart <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SEED;
    cfg_ch.data <= '0;

    seed_reg = SEED_RESET;
    hold_reg = HOLD_RESET;
    len_reg = LEN_RESET;
    foreach (twist_words[i]) twist_words[i] = '0;
    twist_pos = TW_N;
    held_sample = '0;
    hold_left = 0;
    tab_pos = 0;
    reseed_due = 1;
    burst_left = $urandom_range(1, 8);

    // After reset, then one-sample tables (zero length acts as one).
    add_item(0, 1, 0, 0);
    add_item(0, 1, 1, 0);
    add_item(1, 1, 0, 0);
    add_cfg(REG_LEN, 32'h0000_0001);
    add_item(0, 1, 0, 1);
    add_item(1, 1, 0, 1);
    add_cfg(REG_LEN, 32'h0000_0000);
    add_item(0, 1, 0, 1);
    // Zero hold draws every sample; a table of three wraps on its own.
    add_cfg(REG_HOLD, 32'h0000_0000);
    add_cfg(REG_LEN, 32'h0000_0003);
    add_item(0, 1, 0, 0);
    add_item(0, 1, 1, 0);
    add_item(0, 1, 2, 1);
    add_item(0, 1, 0, 0);
    // Seed and hold extremes, and a length beyond the maximum that saturates.
    add_cfg(REG_SEED, 32'h0000_0000);
    add_cfg(REG_HOLD, 32'hFFFF_FFFF);
    add_cfg(REG_LEN, 32'hFFFF_FFFF);
    add_item(1, 1, 0, 0);
    add_item(0, 1, 1, 0);
    add_cfg(REG_SEED, 32'hFFFF_FFFF);
    add_cfg(REG_LEN, 32'h0001_0000);
    add_item(1, 1, 0, 0);
    add_item(0, 1, 1, 0);
    // An unused index must leave all registers alone; a new seed waits for the next table.
    add_cfg(REG_UNUSED, 32'h0000_0001);
    add_cfg(REG_SEED, 32'h1234_5678);
    add_item(0, 1, 2, 0);
    // Shrinking the table below the current position restarts it.
    add_cfg(REG_LEN, 32'h0000_0002);
    add_item(0, 1, 0, 0);
    add_item(0, 1, 1, 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.reg_idx, row.data);
      end else begin
        send_item(row.restart, row.typed, row.index, row.last);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      n_items = 125;
      restart_pct = 3;
      case (ph)
        0: begin
          cfg_write(REG_SEED, $urandom);
          cfg_write(REG_HOLD, with_junk(32'd1, HOLD_W));
          cfg_write(REG_LEN, with_junk($urandom_range(2, 64), LEN_W));
        end
        1: begin
          cfg_write(REG_SEED, 32'h0000_0000);
          cfg_write(REG_HOLD, with_junk($urandom_range(2, 8), HOLD_W));
          cfg_write(REG_LEN, with_junk(32'd2048, LEN_W));
        end
        2: begin
          cfg_write(REG_HOLD, with_junk(32'd64, HOLD_W));
          cfg_write(REG_LEN, with_junk($urandom_range(2, 16), LEN_W));
        end
        3: begin
          cfg_write(REG_SEED, 32'hFFFF_FFFF);
          cfg_write(REG_HOLD, with_junk(32'd65535, HOLD_W));
          cfg_write(REG_LEN, with_junk(32'd65536, LEN_W));
        end
        4: begin
          cfg_write(REG_SEED, $urandom);
          cfg_write(REG_HOLD, with_junk(32'd0, HOLD_W));
          cfg_write(REG_LEN, with_junk($urandom_range(65537, 131071), LEN_W));
        end
        5: begin
          // Every sample starts a table here, so keep the phase short.
          n_items = 12;
          cfg_write(REG_HOLD, with_junk(32'd256, HOLD_W));
          cfg_write(REG_LEN, with_junk(32'd1, LEN_W));
        end
        6: begin
          cfg_write(REG_SEED, $urandom);
          cfg_write(REG_HOLD, with_junk($urandom_range(1, 16), HOLD_W));
          cfg_write(REG_LEN, with_junk($urandom_range(1, 300), LEN_W));
        end
        default: begin
          restart_pct = 10;
          cfg_write(REG_SEED, with_junk(32'd10000, WORD_W));
          cfg_write(REG_HOLD, with_junk(32'd64, HOLD_W));
          cfg_write(REG_LEN, with_junk(32'd2048, LEN_W));
        end
      endcase
      for (int n = 0; n < n_items; n++)
        send_item($urandom_range(0, 99) < restart_pct, 0, '0, 0);
    end

    request_ch.valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("sample_hold_noise_generator: match");
    end else begin
      $display("sample_hold_noise_generator: mismatch");
    end
    $finish;
  end

endmodule
